>>> rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the sorted triangle table
// Entry layout, operation and status codes, cell commands and the corner
// saturation helper.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int DEPTH_DEFAULT = 16;

   // sqrt(3)/2 in unsigned Q0.32.
   localparam logic [31:0] SQRT3_HALF_Q32 = 32'd3719550787;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_DUMP   = 2'd2;

   localparam logic [2:0] STATUS_DONE      = 3'd0;
   localparam logic [2:0] STATUS_FULL      = 3'd1;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [2:0] STATUS_EMPTY     = 3'd3;
   localparam logic [2:0] STATUS_ENTRY     = 3'd4;

   typedef struct packed {
      logic [30:0]        side;
      logic signed [31:0] apex_x;
      logic signed [31:0] apex_y;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   entry;
      logic [32:0] target;
   } cell_cmd_type;

   // Clamp a 34-bit signed value to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic signed [33:0] value);
      logic [31:0] result;
      if (value > 34'sh0_7FFF_FFFF) begin
         result = 32'h7FFF_FFFF;
      end else if (value < -34'sh0_8000_0000) begin
         result = 32'h8000_0000;
      end else begin
         result = value[31:0];
      end
      return result;
   endfunction

endpackage

>>> rtl/stt_req_if.sv
// ----------------------------------------------------------------------------
// stt_req_if: request channel of the sorted triangle table
// One word carries an operation code and the triangle or perimeter operand.
// ----------------------------------------------------------------------------
interface stt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [30:0]        side;
   logic signed [31:0] apex_x;
   logic signed [31:0] apex_y;
   logic [32:0]        target_perimeter;

   modport source (output valid, kind, side, apex_x, apex_y, target_perimeter,
                   input ready);
   modport sink (input valid, kind, side, apex_x, apex_y, target_perimeter,
                 output ready);
endinterface

>>> rtl/stt_rsp_if.sv
// ----------------------------------------------------------------------------
// stt_rsp_if: response channel of the sorted triangle table
// One word carries a status, the entry count and, for a dump, one entry.
// ----------------------------------------------------------------------------
interface stt_rsp_if #(
   parameter int COUNT_W = 5
);
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [COUNT_W-1:0] entry_count;
   logic [32:0]        perimeter;
   logic signed [31:0] top_x;
   logic signed [31:0] top_y;
   logic signed [31:0] left_x;
   logic signed [31:0] left_y;
   logic signed [31:0] right_x;
   logic signed [31:0] right_y;
   logic               last;

   modport source (output valid, status, entry_count, perimeter, top_x, top_y,
                   left_x, left_y, right_x, right_y, last,
                   input ready);
   modport sink (input valid, status, entry_count, perimeter, top_x, top_y,
                 left_x, left_y, right_x, right_y, last,
                 output ready);
endinterface

>>> rtl/stt_cell.sv
// ----------------------------------------------------------------------------
// stt_cell: one slot of the sorted triangle table
// Holds one entry and moves it to or from its neighbors on insert, delete
// and dump rotation.
// ----------------------------------------------------------------------------
module stt_cell #(
   parameter int INDEX   = 0,
   parameter int COUNT_W = 5
) (
   input  logic                     clock,
   input  stt_pkg::cell_cmd_type    cmd,
   input  logic [COUNT_W-1:0]       count,
   input  stt_pkg::entry_type       head_entry,
   input  stt_pkg::entry_type       prev_entry,
   input  logic                     prev_stay,
   input  stt_pkg::entry_type       next_entry,
   input  logic                     found_in,
   output stt_pkg::entry_type       entry_q,
   output logic                     stay_out,
   output logic                     found_out
);

   stt_pkg::entry_type entry_ff;
   stt_pkg::entry_type entry_in;
   logic               in_table;
   logic [32:0]        perimeter;
   logic               is_last;

   assign in_table  = COUNT_W'(INDEX) < count;
   assign is_last   = COUNT_W'(INDEX + 1) == count;
   assign perimeter = {2'b00, entry_ff.side} + {1'b0, entry_ff.side, 1'b0};

   // The table is kept sorted, so the entries that stay in place on insert
   // form a prefix. Slot zero also stays when its side equals the new one.
   always_comb begin
      if (INDEX == 0) begin
         stay_out = in_table && !(cmd.entry.side < entry_ff.side);
      end else begin
         stay_out = in_table && (entry_ff.side < cmd.entry.side);
      end
   end

   assign found_out = found_in || (in_table && (perimeter == cmd.target));

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         stt_pkg::CELL_INSERT: begin
            if (!stay_out) begin
               entry_in = prev_stay ? cmd.entry : prev_entry;
            end
         end
         stt_pkg::CELL_DELETE: begin
            if (found_out) begin
               entry_in = next_entry;
            end
         end
         stt_pkg::CELL_ROTATE: begin
            entry_in = is_last ? head_entry : next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

>>> rtl/sorted_triangle_table.sv
// ----------------------------------------------------------------------------
// sorted_triangle_table: bounded table of triangles kept in order of side
// A chain of slot cells stores the entries; a sequencer issues insert,
// delete and dump commands and formats the response words.
// ----------------------------------------------------------------------------
// Insert and delete: the request word is registered and the response word is
// loaded in the execute state once the response register is free; the next
// request is taken as that word becomes valid. Dump: the chain rotates each
// entry past slot zero into the multiply and format steps, one word per entry
// as the response register frees up. Reset is synchronous, active high: it
// empties the table and clears the sequencer; slot contents stay undefined.
module sorted_triangle_table #(
   parameter int TABLE_DEPTH = stt_pkg::DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   stt_req_if.sink   req_port,
   stt_rsp_if.source rsp_port
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DMUL,
      ST_DOUT
   } state_type;

   state_type             state_ff;
   logic [1:0]            op_kind_ff;
   stt_pkg::entry_type    op_entry_ff;
   logic [32:0]           op_target_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      remain_ff;

   // Dump formatting pipeline: the entry leaving slot zero and its height
   // product.
   stt_pkg::entry_type    pipe_entry_ff;
   logic [62:0]           prod_ff;

   logic                  rsp_valid_ff;
   logic [2:0]            rsp_status_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic [32:0]           rsp_perimeter_ff;
   logic [31:0]           rsp_top_x_ff;
   logic [31:0]           rsp_top_y_ff;
   logic [31:0]           rsp_left_x_ff;
   logic [31:0]           rsp_left_y_ff;
   logic [31:0]           rsp_right_x_ff;
   logic [31:0]           rsp_right_y_ff;
   logic                  rsp_last_ff;

   stt_pkg::cell_cmd_type cmd;
   stt_pkg::entry_type    entry_q [TABLE_DEPTH];
   logic                  stay    [TABLE_DEPTH];
   logic                  found   [TABLE_DEPTH];
   logic                  any_found;
   logic                  out_free;
   logic                  table_full;
   logic                  rsp_load;

   // Corner arithmetic for the entry in the formatting pipeline.
   logic [63:0]           height_sum;
   logic [31:0]           height;
   logic [31:0]           half_up;
   logic signed [33:0]    ax_wide;
   logic signed [33:0]    ay_wide;
   logic signed [33:0]    left_x_wide;
   logic signed [33:0]    right_x_wide;
   logic signed [33:0]    base_y_wide;
   logic [32:0]           perim_out;

   // The response register frees up when it is empty or its word is taken
   // in this cycle, so a result may be loaded while the old one leaves.
   assign out_free   = !rsp_valid_ff || rsp_port.ready;
   assign table_full = count_ff == CNT_W'(TABLE_DEPTH);
   assign any_found  = found[TABLE_DEPTH-1];

   // A new response word is loaded when an insert or delete finishes, when a
   // delete or dump finds the table empty, and for each dumped entry.
   always_comb begin
      rsp_load = 1'b0;
      case (state_ff)
         ST_EXEC: begin
            if (op_kind_ff inside {stt_pkg::KIND_INSERT, stt_pkg::KIND_DELETE}) begin
               rsp_load = out_free;
            end else if (op_kind_ff == stt_pkg::KIND_DUMP) begin
               rsp_load = out_free && count_ff == '0;
            end
         end
         ST_DOUT: begin
            rsp_load = out_free;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Command broadcast to the cell chain.
   // ------------------------------------------------------------------
   always_comb begin
      cmd.op     = stt_pkg::CELL_HOLD;
      cmd.entry  = op_entry_ff;
      cmd.target = op_target_ff;
      case (state_ff)
         ST_EXEC: begin
            if (out_free) begin
               if (op_kind_ff == stt_pkg::KIND_INSERT && !table_full) begin
                  cmd.op = stt_pkg::CELL_INSERT;
               end else if (op_kind_ff == stt_pkg::KIND_DELETE &&
                            count_ff != '0) begin
                  cmd.op = stt_pkg::CELL_DELETE;
               end
            end
         end
         ST_DMUL: begin
            cmd.op = stt_pkg::CELL_ROTATE;
         end
         default: begin
            cmd.op = stt_pkg::CELL_HOLD;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // The chain of cells. Slot zero sees the new entry as its lower
   // neighbor; the top slot sees itself as its upper neighbor.
   // ------------------------------------------------------------------
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      stt_pkg::entry_type prev_entry;
      stt_pkg::entry_type next_entry;
      logic               prev_stay;
      logic               found_in;

      if (i == 0) begin : g_first
         assign prev_entry = op_entry_ff;
         assign prev_stay  = 1'b0;
         assign found_in   = 1'b0;
      end else begin : g_inner
         assign prev_entry = entry_q[i-1];
         assign prev_stay  = stay[i-1];
         assign found_in   = found[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_top
         assign next_entry = entry_q[i];
      end else begin : g_below
         assign next_entry = entry_q[i+1];
      end

      stt_cell #(
         .INDEX   (i),
         .COUNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .head_entry (entry_q[0]),
         .prev_entry (prev_entry),
         .prev_stay  (prev_stay),
         .next_entry (next_entry),
         .found_in   (found_in),
         .entry_q    (entry_q[i]),
         .stay_out   (stay[i]),
         .found_out  (found[i])
      );
   end

   // ------------------------------------------------------------------
   // Corner formatting. The height is side * sqrt(3)/2 rounded half up;
   // the base corners sit half a side to each side of the apex.
   // ------------------------------------------------------------------
   assign height_sum   = {1'b0, prod_ff} + 64'h0000_0000_8000_0000;
   assign height       = height_sum[63:32];
   assign half_up      = ({1'b0, pipe_entry_ff.side} + 32'd1) >> 1;
   assign ax_wide      = {{2{pipe_entry_ff.apex_x[31]}}, pipe_entry_ff.apex_x};
   assign ay_wide      = {{2{pipe_entry_ff.apex_y[31]}}, pipe_entry_ff.apex_y};
   assign left_x_wide  = ax_wide - $signed({4'b0000, pipe_entry_ff.side[30:1]});
   assign right_x_wide = ax_wide + $signed({2'b00, half_up});
   assign base_y_wide  = ay_wide - $signed({2'b00, height});
   assign perim_out    = {2'b00, pipe_entry_ff.side} +
                         {1'b0, pipe_entry_ff.side, 1'b0};

   // ------------------------------------------------------------------
   // Sequencer and response register.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The word stays valid until it is taken, unless a new one is loaded.
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_port.ready);
         case (state_ff)
            ST_IDLE: begin
               if (req_port.valid) begin
                  op_kind_ff   <= req_port.kind;
                  op_entry_ff  <= '{side:   req_port.side,
                                    apex_x: req_port.apex_x,
                                    apex_y: req_port.apex_y};
                  op_target_ff <= req_port.target_perimeter;
                  state_ff     <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (op_kind_ff != stt_pkg::KIND_INSERT &&
                   op_kind_ff != stt_pkg::KIND_DELETE &&
                   op_kind_ff != stt_pkg::KIND_DUMP) begin
                  // An unused operation code is dropped without a word.
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  rsp_perimeter_ff <= '0;
                  rsp_top_x_ff     <= '0;
                  rsp_top_y_ff     <= '0;
                  rsp_left_x_ff    <= '0;
                  rsp_left_y_ff    <= '0;
                  rsp_right_x_ff   <= '0;
                  rsp_right_y_ff   <= '0;
                  rsp_last_ff      <= 1'b1;
                  case (op_kind_ff)
                     stt_pkg::KIND_INSERT: begin
                        state_ff <= ST_IDLE;
                        if (table_full) begin
                           rsp_status_ff <= stt_pkg::STATUS_FULL;
                           rsp_count_ff  <= count_ff;
                        end else begin
                           rsp_status_ff <= stt_pkg::STATUS_DONE;
                           count_ff      <= count_ff + CNT_W'(1);
                           rsp_count_ff  <= count_ff + CNT_W'(1);
                        end
                     end
                     stt_pkg::KIND_DELETE: begin
                        state_ff <= ST_IDLE;
                        if (count_ff == '0) begin
                           rsp_status_ff <= stt_pkg::STATUS_EMPTY;
                           rsp_count_ff  <= count_ff;
                        end else if (any_found) begin
                           rsp_status_ff <= stt_pkg::STATUS_DONE;
                           count_ff      <= count_ff - CNT_W'(1);
                           rsp_count_ff  <= count_ff - CNT_W'(1);
                        end else begin
                           rsp_status_ff <= stt_pkg::STATUS_NOT_FOUND;
                           rsp_count_ff  <= count_ff;
                        end
                     end
                     default: begin
                        if (count_ff == '0) begin
                           rsp_status_ff <= stt_pkg::STATUS_EMPTY;
                           rsp_count_ff  <= count_ff;
                           state_ff      <= ST_IDLE;
                        end else begin
                           // Dump: no word yet; the chain starts rotating.
                           remain_ff <= count_ff;
                           state_ff  <= ST_DMUL;
                        end
                     end
                  endcase
               end
            end
            ST_DMUL: begin
               pipe_entry_ff <= entry_q[0];
               prod_ff       <= 63'(entry_q[0].side) *
                                63'(stt_pkg::SQRT3_HALF_Q32);
               state_ff      <= ST_DOUT;
            end
            ST_DOUT: begin
               if (out_free) begin
                  rsp_status_ff    <= stt_pkg::STATUS_ENTRY;
                  rsp_count_ff     <= count_ff;
                  rsp_perimeter_ff <= perim_out;
                  rsp_top_x_ff     <= pipe_entry_ff.apex_x;
                  rsp_top_y_ff     <= pipe_entry_ff.apex_y;
                  rsp_left_x_ff    <= stt_pkg::sat32(left_x_wide);
                  rsp_left_y_ff    <= stt_pkg::sat32(base_y_wide);
                  rsp_right_x_ff   <= stt_pkg::sat32(right_x_wide);
                  rsp_right_y_ff   <= stt_pkg::sat32(base_y_wide);
                  rsp_last_ff      <= remain_ff == CNT_W'(1);
                  remain_ff        <= remain_ff - CNT_W'(1);
                  state_ff         <= (remain_ff == CNT_W'(1)) ? ST_IDLE : ST_DMUL;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_port.ready       = state_ff == ST_IDLE;

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.status      = rsp_status_ff;
   assign rsp_port.entry_count = rsp_count_ff;
   assign rsp_port.perimeter   = rsp_perimeter_ff;
   assign rsp_port.top_x       = rsp_top_x_ff;
   assign rsp_port.top_y       = rsp_top_y_ff;
   assign rsp_port.left_x      = rsp_left_x_ff;
   assign rsp_port.left_y      = rsp_left_y_ff;
   assign rsp_port.right_x     = rsp_right_x_ff;
   assign rsp_port.right_y     = rsp_right_y_ff;
   assign rsp_port.last        = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |->
         (count_ff == $past(count_ff) + CNT_W'(1) ||
          count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("entry count moved by more than one");

   a_dump_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DMUL || state_ff == ST_DOUT) |->
         (count_ff != '0 && remain_ff != '0 && remain_ff <= count_ff))
      else $error("dump running on an empty table");

   a_count_only_in_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EXEC) |=> $stable(count_ff))
      else $error("entry count changed outside of an operation");

   if (TABLE_DEPTH > 1) begin : g_order_check
      a_sorted_head: assert property (@(posedge clock) disable iff (reset)
         (state_ff == ST_IDLE && count_ff >= CNT_W'(2)) |->
            (entry_q[0].side <= entry_q[1].side))
         else $error("table head is out of order");
   end

endmodule
